// ===== rtl/afc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the box-versus-frustum cull block
// Matrix layout, clip plane coefficients, input item layout and the
// helpers that form a plane from the view-projection matrix.
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int NumPairs  = 8;
	localparam int NumPlanes = 6;
	localparam int PairW     = 64;
	localparam int ElemW     = 32;
	// plane components are exact sums or differences of two elements
	localparam int CoefW     = ElemW + 1;
	// |A|+|B|+|C| is at most 3 * 2^32
	localparam int SpreadW   = CoefW + 1;

	typedef logic [NumPairs-1:0][PairW-1:0] mat_t;
	typedef logic [SpreadW-1:0]              spread_t;

	typedef struct packed {
		logic signed [CoefW-1:0] a;
		logic signed [CoefW-1:0] b;
		logic signed [CoefW-1:0] c;
		logic signed [CoefW-1:0] d;
	} plane_t;

	// one input item, last field in the low bits
	typedef struct packed {
		logic        [ElemW-1:0] box_size;
		logic signed [ElemW-1:0] center_z;
		logic signed [ElemW-1:0] center_y;
		logic signed [ElemW-1:0] center_x;
	} box_t;

	// identity matrix in Q16.16, pair 7 down to pair 0
	localparam mat_t MatReset = {
		64'd281474976710656, 64'd0, 64'd65536, 64'd0,
		64'd0, 64'd281474976710656, 64'd0, 64'd65536
	};

	// matrix element i, sign-extended by one bit
	function automatic logic signed [CoefW-1:0] elem(input mat_t m, input logic [3:0] i);
		logic [ElemW-1:0] e;
		e = i[0] ? m[i[3:1]][PairW-1:ElemW] : m[i[3:1]][ElemW-1:0];
		return $signed({e[ElemW-1], e});
	endfunction

	// plane p: left, right, bottom, top, near, far
	function automatic plane_t plane_of(input mat_t m, input logic [2:0] p);
		logic [1:0] k;
		logic       minus;
		plane_t     pl;
		k     = p[2:1];
		minus = p[0];
		pl.a = minus ? elem(m, 4'd3)  - elem(m, {2'b00, k}) : elem(m, 4'd3)  + elem(m, {2'b00, k});
		pl.b = minus ? elem(m, 4'd7)  - elem(m, {2'b01, k}) : elem(m, 4'd7)  + elem(m, {2'b01, k});
		pl.c = minus ? elem(m, 4'd11) - elem(m, {2'b10, k}) : elem(m, 4'd11) + elem(m, {2'b10, k});
		pl.d = minus ? elem(m, 4'd15) - elem(m, {2'b11, k}) : elem(m, 4'd15) + elem(m, {2'b11, k});
		return pl;
	endfunction

	// |A| + |B| + |C|
	function automatic spread_t spread_of(input plane_t pl);
		logic [CoefW-1:0] aa;
		logic [CoefW-1:0] ab;
		logic [CoefW-1:0] ac;
		aa = pl.a[CoefW-1] ? CoefW'(-pl.a) : CoefW'(pl.a);
		ab = pl.b[CoefW-1] ? CoefW'(-pl.b) : CoefW'(pl.b);
		ac = pl.c[CoefW-1] ? CoefW'(-pl.c) : CoefW'(pl.c);
		return SpreadW'(aa) + SpreadW'(ab) + SpreadW'(ac);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/afc_plane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afc_plane: matrix registers and clip plane coefficients
// Holds the eight matrix pair registers and keeps registered copies of the
// six plane coefficient sets and their corner spreads.
// ----------------------------------------------------------------------------
module afc_plane
	import afc_pkg::*;
(
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [2:0]                     cfg_idx,
	input  wire logic [PairW-1:0]               cfg_wdata,
	output plane_t    [NumPlanes-1:0]           planes,
	output spread_t   [NumPlanes-1:0]           spreads
);

	mat_t                           mat_q;
	plane_t  [NumPlanes-1:0]        plane_q;
	spread_t [NumPlanes-1:0]        spread_q;

	// matrix registers, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= MatReset;
		end else if (cfg_we) begin
			mat_q[cfg_idx] <= cfg_wdata;
		end
	end

	// plane coefficients are registered from the matrix, spreads from the registered coefficients
	always_ff @(posedge clk) begin
		for (int p = 0; p < NumPlanes; p++) begin
			plane_q[p]  <= plane_of(mat_q, 3'(p));
			spread_q[p] <= spread_of(plane_q[p]);
		end
	end

	assign planes  = plane_q;
	assign spreads = spread_q;

endmodule
`default_nettype wire

// ===== rtl/afc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afc_datapath: five-stage plane test pipeline
// s1 doubles the center, s2 multiplies by A, B, C, s3 forms the size term
// and first sums, s4 adds further, s5 takes the sign of each plane total.
// ----------------------------------------------------------------------------
module afc_datapath
	import afc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire box_t                     in_box,
	input  wire plane_t  [NumPlanes-1:0]  planes,
	input  wire spread_t [NumPlanes-1:0]  spreads,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          out_visible
);

	localparam int ProdW = 2 * CoefW;
	localparam int SumW  = ProdW + 1;
	localparam int AccW  = ProdW + 2;
	localparam int TotW  = ProdW + 3;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [CoefW-1:0] x2_s1, y2_s1, z2_s1;
	logic        [ElemW-1:0] size_s1, size_s2;

	logic signed [ProdW-1:0] pax_s2 [NumPlanes];
	logic signed [ProdW-1:0] pby_s2 [NumPlanes];
	logic signed [ProdW-1:0] pcz_s2 [NumPlanes];

	logic signed [SumW-1:0]  pab_s3 [NumPlanes];
	logic signed [SumW-1:0]  pcd_s3 [NumPlanes];
	logic        [ProdW-1:0] psp_s3 [NumPlanes];

	logic signed [AccW-1:0]  pabcd_s4 [NumPlanes];
	logic        [ProdW-1:0] psp_s4   [NumPlanes];

	logic signed [TotW-1:0]  total    [NumPlanes];
	logic [NumPlanes-1:0]    neg;
	logic                    visible_s5;

	// per-stage load enables, bubbles collapse
	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// s1: doubled center, so the half edge needs no rounding
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x2_s1   <= {in_box.center_x, 1'b0};
			y2_s1   <= {in_box.center_y, 1'b0};
			z2_s1   <= {in_box.center_z, 1'b0};
			size_s1 <= in_box.box_size;
		end
	end

	// s2: center terms
	always_ff @(posedge clk) begin
		if (en_s2) begin
			size_s2 <= size_s1;
			for (int p = 0; p < NumPlanes; p++) begin
				pax_s2[p] <= ProdW'(planes[p].a) * ProdW'(x2_s1);
				pby_s2[p] <= ProdW'(planes[p].b) * ProdW'(y2_s1);
				pcz_s2[p] <= ProdW'(planes[p].c) * ProdW'(z2_s1);
			end
		end
	end

	// s3: size term, pairwise sums, D scaled by 2^17
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int p = 0; p < NumPlanes; p++) begin
				pab_s3[p] <= SumW'(pax_s2[p]) + SumW'(pby_s2[p]);
				pcd_s3[p] <= SumW'(pcz_s2[p])
					+ $signed({{17{planes[p].d[CoefW-1]}}, planes[p].d, 17'd0});
				psp_s3[p] <= ProdW'(size_s2) * ProdW'(spreads[p]);
			end
		end
	end

	// s4: center terms plus D
	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int p = 0; p < NumPlanes; p++) begin
				pabcd_s4[p] <= AccW'(pab_s3[p]) + AccW'(pcd_s3[p]);
				psp_s4[p]   <= psp_s3[p];
			end
		end
	end

	// farthest corner value per plane, culled if any is negative
	always_comb begin
		for (int p = 0; p < NumPlanes; p++) begin
			total[p] = TotW'(pabcd_s4[p]) + $signed({3'b000, psp_s4[p]});
			neg[p]   = total[p][TotW-1];
		end
	end

	// s5: result
	always_ff @(posedge clk) begin
		if (en_s5) begin
			visible_s5 <= ~|neg;
		end
	end

	assign out_valid   = v_s5;
	assign out_visible = visible_s5;

	// input stalls only when every stage holds an item and the output is blocked
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en_s1 |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready))
		else $error("input stalled with a bubble in the pipe");

	// a blocked result stays in s5 unchanged
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !out_ready |=> v_s5 && $stable(visible_s5))
		else $error("blocked result lost or changed");

	// an item in s4 moves on or stays, never vanishes
	a_keep_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> (v_s4 || v_s5))
		else $error("item dropped between s4 and s5");

endmodule
`default_nettype wire

// ===== rtl/afc_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afc_skid: output register with a spare entry
// Breaks the ready path from the output side back into the pipeline.
// ----------------------------------------------------------------------------
module afc_skid (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      out_data
);

	logic out_v_q, spare_v_q;
	logic out_d_q, spare_d_q;

	assign in_ready = !spare_v_q;

	// valid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q   <= spare_v_q || in_valid;
			spare_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			spare_v_q <= 1'b1;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_d_q <= spare_v_q ? spare_d_q : in_data;
		end else if (in_valid && in_ready) begin
			spare_d_q <= in_data;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	// spare only fills behind a held output
	a_spare_order: assert property (@(posedge clk) disable iff (!arst_n)
		spare_v_q |-> out_v_q)
		else $error("spare entry valid with empty output");

	// an item arriving at a blocked output lands in the spare
	a_spare_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready && in_valid && in_ready |=> spare_v_q)
		else $error("item lost at blocked output");

	// spare only rises when the output was blocked
	a_spare_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(spare_v_q) |-> $past(out_v_q && !out_ready))
		else $error("spare filled while output was free");

endmodule
`default_nettype wire

// ===== rtl/aabb_frustum_cull.sv =====
`default_nettype none
// Path: five pipe stages and then the output register, from the accepting edge to m_axis.
// Throughput: one box per cycle while m_axis_tready does not stall the pipeline;
//   24 multipliers (18 of 33x33, 6 of 32x34) work in parallel.
// Reset: clears all valid bits and loads the identity matrix; after a matrix write or
//   reset release, plane coefficients and then spreads settle through their registers.
// ----------------------------------------------------------------------------
// aabb_frustum_cull: cube bounding box versus view frustum visibility test
// Six clip planes come from the view-projection matrix; a box is culled when
// its farthest corner lies strictly behind any plane.
// ----------------------------------------------------------------------------
module aabb_frustum_cull
	import afc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input items
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,  // center_x, center_y, center_z, box_size
	// result items
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // visible, zero fill
	// configuration writes
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_idx,
	input  wire logic [63:0]  cfg_wdata
);

	plane_t  [NumPlanes-1:0] planes;
	spread_t [NumPlanes-1:0] spreads;
	box_t                    box;
	logic                    pipe_valid;
	logic                    pipe_ready;
	logic                    pipe_visible;
	logic                    visible;

	assign box = box_t'(s_axis_tdata);

	// matrix and plane coefficients
	afc_plane u_plane (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.planes    (planes),
		.spreads   (spreads)
	);

	// plane test pipeline
	afc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_box      (box),
		.planes      (planes),
		.spreads     (spreads),
		.out_valid   (pipe_valid),
		.out_ready   (pipe_ready),
		.out_visible (pipe_visible)
	);

	// output register
	afc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_valid),
		.in_ready  (pipe_ready),
		.in_data   (pipe_visible),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (visible)
	);

	assign m_axis_tdata = {7'd0, visible};

endmodule
`default_nettype wire
